// File: design/aahc_pkg.sv
// package for the adc averaging and hysteresis cutoff block
// register indexes, reset values, fixed field widths and the ring command
// no dependencies
`default_nettype none

package aahc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_COMPARE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONDUCTION_COMPARE = 2'd3;

    localparam logic [CFG_W-1:0] UPPER_RESET      = 16'd40503;
    localparam logic [CFG_W-1:0] LOWER_RESET      = 16'd38120;
    localparam logic [CFG_W-1:0] CUTOFF_CMP_RESET = 16'd7200;
    localparam logic [CFG_W-1:0] CONDUCT_CMP_RESET = 16'd0;

    typedef struct packed {
        logic                push;
        logic [SAMPLE_W-1:0] value;
    } ring_cmd_t;

endpackage

`default_nettype wire

// File: design/aahc_divider.sv
// restoring divider, one quotient bit per cycle
// used for the ring average; no dependencies
`default_nettype none

module aahc_divider #(
    parameter int NW = 16,
    parameter int DW = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    den_reg;

    logic [DW:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= DW'(trial - {1'b0, den_reg});
            else
                rem_reg <= trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: design/aahc_acc_mem.sv
// per-channel accumulator memory with registered read
// valid bits make unwritten or cleared entries read as zero; no dependencies
`default_nettype none

module aahc_acc_mem #(
    parameter int CHANNELS = 3,
    parameter int ACC_W    = 15
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                rd_en,
    input  wire logic [$clog2(CHANNELS+1)-1:0]       rd_addr,
    output logic [ACC_W-1:0]                         rd_data,
    input  wire logic                                wr_en,
    input  wire logic [$clog2(CHANNELS+1)-1:0]       wr_addr,
    input  wire logic [ACC_W-1:0]                    wr_data,
    input  wire logic                                clear
);

    logic [ACC_W-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [ACC_W-1:0]    rdata_reg;
    logic                rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rvalid_reg <= valid_reg[rd_addr];
            if (clear)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

// File: design/aahc_ring.sv
// moving-average ring: memory, write index, fill count and running sum
// uses aahc_pkg::ring_cmd_t; read-modify-write as a registered read, then a write-back phase
`default_nettype none

module aahc_ring #(
    parameter int RING_DEPTH = 16,
    parameter int SUM_W      = 16,
    parameter int CNT_W      = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire aahc_pkg::ring_cmd_t cmd,
    output logic [SUM_W-1:0]        sum,
    output logic [CNT_W-1:0]        fill,
    output logic                    done
);

    localparam int IDX_W = $clog2(RING_DEPTH);

    logic [aahc_pkg::SAMPLE_W-1:0] store [RING_DEPTH];
    logic [aahc_pkg::SAMPLE_W-1:0] old_reg;
    logic [aahc_pkg::SAMPLE_W-1:0] val_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              fill_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic                          phase_reg;
    logic                          done_reg;

    logic                          full;
    logic [SUM_W-1:0]              sum_next;

    // entries past the fill count were never written and count as zero
    assign full     = fill_reg == CNT_W'(RING_DEPTH);
    assign sum_next = sum_reg - (full ? SUM_W'(old_reg) : '0) + SUM_W'(val_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            old_reg <= store[idx_reg];
            val_reg <= cmd.value;
        end
        if (phase_reg)
            store[idx_reg] <= val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            phase_reg <= cmd.push;
            if (phase_reg)
            begin
                sum_reg  <= sum_next;
                done_reg <= 1'b1;
                if (idx_reg == IDX_W'(RING_DEPTH - 1))
                    idx_reg <= '0;
                else
                    idx_reg <= idx_reg + 1'b1;
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: design/adc_average_hysteresis_cutoff.sv
// top level: sample sequencer, config registers, hysteresis compare, output register
// depends on aahc_pkg, aahc_divider, aahc_acc_mem, aahc_ring
//
//  channel   signals                                   direction
//  input     in_valid, in_stall, sample                in
//  result    out_valid, out_stall, averages, state     out
//  config    cfg_write, cfg_index, cfg_data            in
//
// a sample that does not close a frame set goes through an accumulator read,
// then add and write back. the closing sample then computes K = min(CHANNELS,3)
// block averages by reciprocal multiply, each a read and a calculate step,
// updates the ring and runs the bit-serial divide of the SUM_W-bit ring sum
// (16 by default) by the fill count. reset clears all control state,
// no clearing pass. a stalled result holds in the output register; the
// next frame set waits only if its result is ready before that one is taken.
`default_nettype none

module adc_average_hysteresis_cutoff #(
    parameter int CHANNELS    = 3,
    parameter int FRAMES      = 8,
    parameter int RING_DEPTH  = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [aahc_pkg::SAMPLE_W-1:0]      sample,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [aahc_pkg::SAMPLE_W-1:0]           bus_block_avg,
    output logic [aahc_pkg::SAMPLE_W-1:0]           aux_one_avg,
    output logic [aahc_pkg::SAMPLE_W-1:0]           aux_two_avg,
    output logic [aahc_pkg::SAMPLE_W-1:0]           filtered_avg,
    output logic                                    cutoff,
    output logic                                    state_changed,
    output logic [aahc_pkg::CFG_W-1:0]              drive_compare,
    input  wire logic                               cfg_write,
    input  wire logic [aahc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [aahc_pkg::CFG_W-1:0]         cfg_data
);

    localparam int SW      = aahc_pkg::SAMPLE_W;
    localparam int CW      = aahc_pkg::CFG_W;
    localparam int FR_SH   = $clog2(FRAMES);
    localparam int ACC_W   = SW + FR_SH;
    localparam int SUM_W   = SW + $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int CH_W    = $clog2(CHANNELS + 1);
    localparam int FR_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int OUT_CH  = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int LHS_W   = SUM_W + 4;
    localparam int RHS_W   = CW + CNT_W;
    localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    // block average as a multiply by the rounded-up reciprocal of FRAMES
    localparam int AVG_SH  = ACC_W + FR_SH;
    localparam int RECIP_W = AVG_SH + 1;
    localparam int PROD_W  = ACC_W + RECIP_W;
    localparam logic [63:0] AVG_RECIP =
        ((64'd1 << AVG_SH) + 64'(FRAMES) - 64'd1) / 64'(FRAMES);
    localparam logic [SW-1:0] SAMPLE_MASK = SW'((32'd1 << SAMPLE_BITS) - 32'd1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_AVG_RD,
        S_AVG_CALC,
        S_RING_WAIT,
        S_FILT_WAIT,
        S_CMP
    } state_t;

    state_t          state_reg;
    logic [CH_W-1:0] chan_pos_reg;
    logic [FR_W-1:0] frame_pos_reg;
    logic [1:0]      avg_idx_reg;
    logic [SW-1:0]   sample_reg;
    logic            cut_reg;

    logic [CW-1:0] upper_reg;
    logic [CW-1:0] lower_reg;
    logic [CW-1:0] cut_cmp_reg;
    logic [CW-1:0] cond_cmp_reg;

    logic [SW-1:0] bus_reg;
    logic [SW-1:0] aux_one_reg;
    logic [SW-1:0] aux_two_reg;

    logic          out_valid_reg;
    logic [SW-1:0] out_bus_reg;
    logic [SW-1:0] out_aux_one_reg;
    logic [SW-1:0] out_aux_two_reg;
    logic [SW-1:0] filt_reg;
    logic          out_cut_reg;
    logic          changed_reg;
    logic [CW-1:0] drive_reg;

    // memory, ring and divider hookup
    logic             acc_rd_en;
    logic [CH_W-1:0]  acc_rd_addr;
    logic [ACC_W-1:0] acc_rd_data;
    logic             acc_wr_en;
    logic [ACC_W-1:0] acc_wr_data;
    logic             acc_clear;

    aahc_pkg::ring_cmd_t ring_cmd;
    logic [SUM_W-1:0]    ring_sum;
    logic [CNT_W-1:0]    ring_fill;
    logic                ring_done;

    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    logic              last_avg;
    logic [PROD_W-1:0] avg_prod;
    logic [SW-1:0]     avg_value;
    logic              out_free;
    logic [CMP_W-1:0]  scaled;
    logic [CMP_W-1:0]  upper_lim;
    logic [CMP_W-1:0]  lower_lim;
    logic              cut_next;

    assign last_avg  = avg_idx_reg == 2'(OUT_CH - 1);
    assign avg_prod  = PROD_W'(acc_rd_data) * PROD_W'(AVG_RECIP[RECIP_W-1:0]);
    assign avg_value = avg_prod[AVG_SH +: SW] & SAMPLE_MASK;
    assign out_free  = !out_valid_reg || !out_stall;

    assign acc_rd_en   = (state_reg == S_IDLE && in_valid) || state_reg == S_AVG_RD;
    assign acc_rd_addr = (state_reg == S_IDLE) ? chan_pos_reg : CH_W'(avg_idx_reg);
    assign acc_wr_en   = state_reg == S_ACC;
    assign acc_wr_data = acc_rd_data + ACC_W'(sample_reg);
    assign acc_clear   = state_reg == S_AVG_CALC && last_avg;

    assign ring_cmd.push  = acc_clear;
    assign ring_cmd.value = (avg_idx_reg == 2'd0) ? avg_value : bus_reg;

    assign div_start = state_reg == S_RING_WAIT && ring_done;

    // hysteresis test in Q12.4: sum*16 against threshold*count
    assign scaled    = CMP_W'({ring_sum, 4'b0000});
    assign upper_lim = CMP_W'(upper_reg * ring_fill);
    assign lower_lim = CMP_W'(lower_reg * ring_fill);

    always_comb
    begin
        if (scaled > upper_lim)
            cut_next = 1'b1;
        else if (scaled < lower_lim)
            cut_next = 1'b0;
        else
            cut_next = cut_reg;
    end

    aahc_acc_mem #(
        .CHANNELS (CHANNELS),
        .ACC_W    (ACC_W)
    ) u_acc_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (acc_rd_en),
        .rd_addr (acc_rd_addr),
        .rd_data (acc_rd_data),
        .wr_en   (acc_wr_en),
        .wr_addr (chan_pos_reg),
        .wr_data (acc_wr_data),
        .clear   (acc_clear)
    );

    aahc_ring #(
        .RING_DEPTH (RING_DEPTH),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .sum   (ring_sum),
        .fill  (ring_fill),
        .done  (ring_done)
    );

    aahc_divider #(
        .NW (SUM_W),
        .DW (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (ring_sum),
        .den      (ring_fill),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg    <= aahc_pkg::UPPER_RESET;
            lower_reg    <= aahc_pkg::LOWER_RESET;
            cut_cmp_reg  <= aahc_pkg::CUTOFF_CMP_RESET;
            cond_cmp_reg <= aahc_pkg::CONDUCT_CMP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                aahc_pkg::REG_UPPER_THRESHOLD:    upper_reg    <= cfg_data;
                aahc_pkg::REG_LOWER_THRESHOLD:    lower_reg    <= cfg_data;
                aahc_pkg::REG_CUTOFF_COMPARE:     cut_cmp_reg  <= cfg_data;
                aahc_pkg::REG_CONDUCTION_COMPARE: cond_cmp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chan_pos_reg    <= '0;
            frame_pos_reg   <= '0;
            avg_idx_reg     <= '0;
            sample_reg      <= '0;
            cut_reg         <= 1'b1;
            bus_reg         <= '0;
            aux_one_reg     <= '0;
            aux_two_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_bus_reg     <= '0;
            out_aux_one_reg <= '0;
            out_aux_two_reg <= '0;
            filt_reg        <= '0;
            out_cut_reg     <= 1'b1;
            changed_reg     <= 1'b0;
            drive_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample & SAMPLE_MASK;
                        state_reg  <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    state_reg <= S_IDLE;
                    if (chan_pos_reg == CH_W'(CHANNELS - 1))
                    begin
                        chan_pos_reg <= '0;
                        if (frame_pos_reg == FR_W'(FRAMES - 1))
                        begin
                            frame_pos_reg <= '0;
                            avg_idx_reg   <= '0;
                            aux_one_reg   <= '0;
                            aux_two_reg   <= '0;
                            state_reg     <= S_AVG_RD;
                        end
                        else
                        begin
                            frame_pos_reg <= frame_pos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        chan_pos_reg <= chan_pos_reg + 1'b1;
                    end
                end
                S_AVG_RD:
                begin
                    state_reg <= S_AVG_CALC;
                end
                S_AVG_CALC:
                begin
                    case (avg_idx_reg)
                        2'd0:    bus_reg     <= avg_value;
                        2'd1:    aux_one_reg <= avg_value;
                        default: aux_two_reg <= avg_value;
                    endcase
                    if (last_avg)
                    begin
                        state_reg <= S_RING_WAIT;
                    end
                    else
                    begin
                        avg_idx_reg <= avg_idx_reg + 1'b1;
                        state_reg   <= S_AVG_RD;
                    end
                end
                S_RING_WAIT:
                begin
                    if (ring_done)
                        state_reg <= S_FILT_WAIT;
                end
                S_FILT_WAIT:
                begin
                    if (div_done)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    // hold the new result until the output register frees up
                    if (out_free)
                    begin
                        cut_reg         <= cut_next;
                        out_bus_reg     <= bus_reg;
                        out_aux_one_reg <= aux_one_reg;
                        out_aux_two_reg <= aux_two_reg;
                        filt_reg        <= div_quo[SW-1:0];
                        out_cut_reg     <= cut_next;
                        changed_reg     <= cut_next != cut_reg;
                        drive_reg       <= cut_next ? cut_cmp_reg : cond_cmp_reg;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = out_valid_reg;
    assign bus_block_avg = out_bus_reg;
    assign aux_one_avg   = out_aux_one_reg;
    assign aux_two_avg   = out_aux_two_reg;
    assign filtered_avg  = filt_reg;
    assign cutoff        = out_cut_reg;
    assign state_changed = changed_reg;
    assign drive_compare = drive_reg;

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for adc_average_hysteresis_cutoff: predicts frame set averages, ring filter
// and hysteresis state, and checks every result transfer against the prediction
// depends on aahc_pkg and the adc_average_hysteresis_cutoff rtl
module tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD = 600;

    typedef struct {
        logic [aahc_pkg::SAMPLE_W-1:0] bus;
        logic [aahc_pkg::SAMPLE_W-1:0] aux_one;
        logic [aahc_pkg::SAMPLE_W-1:0] aux_two;
        logic [aahc_pkg::SAMPLE_W-1:0] filt;
        logic                          cut;
        logic                          changed;
        logic [aahc_pkg::CFG_W-1:0]    cmp;
    } frame_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [aahc_pkg::SAMPLE_W-1:0]  sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [aahc_pkg::SAMPLE_W-1:0]  bus_block_avg;
    logic [aahc_pkg::SAMPLE_W-1:0]  aux_one_avg;
    logic [aahc_pkg::SAMPLE_W-1:0]  aux_two_avg;
    logic [aahc_pkg::SAMPLE_W-1:0]  filtered_avg;
    logic                           cutoff;
    logic                           state_changed;
    logic [aahc_pkg::CFG_W-1:0]     drive_compare;
    logic                           cfg_write = 1'b0;
    logic [aahc_pkg::CFG_IDX_W-1:0] cfg_index = aahc_pkg::REG_UPPER_THRESHOLD;
    logic [aahc_pkg::CFG_W-1:0]     cfg_data = '0;

    // predictor copy of the block state and its registers
    logic [aahc_pkg::CFG_W-1:0]    thr_upper = aahc_pkg::UPPER_RESET;
    logic [aahc_pkg::CFG_W-1:0]    thr_lower = aahc_pkg::LOWER_RESET;
    logic [aahc_pkg::CFG_W-1:0]    cmp_cutoff = aahc_pkg::CUTOFF_CMP_RESET;
    logic [aahc_pkg::CFG_W-1:0]    cmp_conduct = aahc_pkg::CONDUCT_CMP_RESET;
    logic [14:0]                   chan_acc [3] = '{default: '0};
    logic [1:0]                    chan_pos = '0;
    logic [2:0]                    frame_pos = '0;
    logic [aahc_pkg::SAMPLE_W-1:0] ring_mem [16] = '{default: '0};
    logic [3:0]                    ring_ptr = '0;
    logic [4:0]                    ring_fill = '0;
    logic [15:0]                   ring_total = '0;
    logic                          cut_state = 1'b1;

    frame_result_t                 frame_results_due [$];
    logic [aahc_pkg::SAMPLE_W-1:0] sample_queue [$];
    int unsigned                   mismatches = 0;

    // stimulus generator position and bus level
    int unsigned gen_chan = 0;
    int unsigned gen_frame = 0;
    int          bus_level = 0;
    logic        level_high = 1'b0;

    adc_average_hysteresis_cutoff dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bus_block_avg (bus_block_avg),
        .aux_one_avg   (aux_one_avg),
        .aux_two_avg   (aux_two_avg),
        .filtered_avg  (filtered_avg),
        .cutoff        (cutoff),
        .state_changed (state_changed),
        .drive_compare (drive_compare),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void predict_sample(input logic [aahc_pkg::SAMPLE_W-1:0] value);
        frame_result_t r;
        int unsigned   scaled;
        int unsigned   upper_lim;
        int unsigned   lower_lim;
        logic          next_cut;
        chan_acc[chan_pos] = chan_acc[chan_pos] + 15'(value);
        if (chan_pos != 2'd2)
        begin
            chan_pos = chan_pos + 2'd1;
            return;
        end
        chan_pos = '0;
        if (frame_pos != 3'd7)
        begin
            frame_pos = frame_pos + 3'd1;
            return;
        end
        frame_pos = '0;
        r.bus = 12'(chan_acc[0] >> 3);
        r.aux_one = 12'(chan_acc[1] >> 3);
        r.aux_two = 12'(chan_acc[2] >> 3);
        chan_acc = '{default: '0};
        // running sum drops the oldest entry and takes the new block average
        ring_total = ring_total - 16'(ring_mem[ring_ptr]) + 16'(r.bus);
        ring_mem[ring_ptr] = r.bus;
        ring_ptr = ring_ptr + 4'd1;
        if (ring_fill != 5'd16)
            ring_fill = ring_fill + 5'd1;
        r.filt = 12'(32'(ring_total) / 32'(ring_fill));
        scaled = 32'(ring_total) << 4;
        upper_lim = 32'(thr_upper) * 32'(ring_fill);
        lower_lim = 32'(thr_lower) * 32'(ring_fill);
        next_cut = cut_state;
        // cutoff test first, so it wins when the thresholds are crossed
        if (scaled > upper_lim)
            next_cut = 1'b1;
        else if (scaled < lower_lim)
            next_cut = 1'b0;
        r.changed = next_cut != cut_state;
        r.cut = next_cut;
        r.cmp = next_cut ? cmp_cutoff : cmp_conduct;
        cut_state = next_cut;
        frame_results_due.push_back(r);
    endfunction

    function automatic int clip_code(input int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // random samples; the bus channel mostly follows a level picked per frame set that
    // usually sits just above or below a threshold so that the ring average wanders across
    task automatic queue_samples(input int count);
        int          pick;
        logic [11:0] v;
        for (int i = 0; i < count; i++)
        begin
            if (gen_chan == 0 && gen_frame == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    if ($urandom_range(0, 3) == 0)
                        level_high = !level_high;
                    if (level_high)
                        bus_level = clip_code(int'(thr_upper >> 4) + $urandom_range(0, 300));
                    else
                        bus_level = clip_code(int'(thr_lower >> 4) - $urandom_range(0, 300));
                end
                else if (pick == 7)
                    bus_level = $urandom_range(0, 4095);
                else if (pick == 8)
                    bus_level = 0;
                else
                    bus_level = 4095;
            end
            if (gen_chan == 0 && $urandom_range(0, 15) != 0)
                v = 12'(clip_code(bus_level + $urandom_range(0, 128) - 64));
            else if ($urandom_range(0, 7) == 0)
                v = $urandom_range(0, 1) ? 12'hfff : 12'h000;
            else
                v = 12'($urandom_range(0, 4095));
            sample_queue.push_back(v);
            gen_chan = gen_chan + 1;
            if (gen_chan == 3)
            begin
                gen_chan = 0;
                gen_frame = (gen_frame + 1) % 8;
            end
        end
    endtask

    task automatic write_config(input logic [aahc_pkg::CFG_W-1:0] upper,
                                input logic [aahc_pkg::CFG_W-1:0] lower,
                                input logic [aahc_pkg::CFG_W-1:0] cut_cmp,
                                input logic [aahc_pkg::CFG_W-1:0] cond_cmp);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= aahc_pkg::REG_UPPER_THRESHOLD;
        cfg_data <= upper;
        @(posedge clk);
        cfg_index <= aahc_pkg::REG_LOWER_THRESHOLD;
        cfg_data <= lower;
        @(posedge clk);
        cfg_index <= aahc_pkg::REG_CUTOFF_COMPARE;
        cfg_data <= cut_cmp;
        @(posedge clk);
        cfg_index <= aahc_pkg::REG_CONDUCTION_COMPARE;
        cfg_data <= cond_cmp;
        @(posedge clk);
        cfg_write <= 1'b0;
        thr_upper = upper;
        thr_lower = lower;
        cmp_cutoff = cut_cmp;
        cmp_conduct = cond_cmp;
    endtask

    // wait until every queued sample is taken and every frame set result has come,
    // looking between edges so the driven signals have settled, then idle a while
    task automatic drain;
        while (sample_queue.size() != 0 || in_valid || frame_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : sender
        int unsigned                   burst_left;
        int unsigned                   gap_left;
        logic                          nxt_valid;
        logic [aahc_pkg::SAMPLE_W-1:0] nxt_sample;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_sample(sample);
            nxt_valid = 1'b0;
            nxt_sample = sample;
            if (gap_left != 0)
                gap_left--;
            else if (sample_queue.size() != 0)
            begin
                nxt_valid = 1'b1;
                nxt_sample = sample_queue.pop_front();
                if (burst_left != 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            in_valid <= nxt_valid;
            sample <= nxt_sample;
        end
    end

    // receiver: alternating stall and free runs, plus long hold-offs that back up the block
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int unsigned taken_count;
        int unsigned next_hold_at;
        int unsigned hold_left;
        int unsigned run_left;
        logic        stalling;
        logic        stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            taken_count = 0;
            next_hold_at = 6;
            hold_left = 0;
            run_left = 0;
            stalling = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                taken_count++;
            if (hold_left != 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (taken_count >= next_hold_at)
            begin
                hold_left = LONG_HOLD;
                next_hold_at = next_hold_at + 24;
                stall_next = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 20) : $urandom_range(1, 60);
                end
                else
                    run_left--;
                stall_next = stalling;
            end
            out_stall <= stall_next;
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_results_due.size() == 0)
                note_mismatch("unexpected result, bus_block_avg", 0, bus_block_avg);
            else
            begin
                want = frame_results_due.pop_front();
                if (bus_block_avg !== want.bus)
                    note_mismatch("bus_block_avg", want.bus, bus_block_avg);
                if (aux_one_avg !== want.aux_one)
                    note_mismatch("aux_one_avg", want.aux_one, aux_one_avg);
                if (aux_two_avg !== want.aux_two)
                    note_mismatch("aux_two_avg", want.aux_two, aux_two_avg);
                if (filtered_avg !== want.filt)
                    note_mismatch("filtered_avg", want.filt, filtered_avg);
                if (cutoff !== want.cut)
                    note_mismatch("cutoff", want.cut, cutoff);
                if (state_changed !== want.changed)
                    note_mismatch("state_changed", want.changed, state_changed);
                if (drive_compare !== want.cmp)
                    note_mismatch("drive_compare", want.cmp, drive_compare);
            end
        end
    end

    // watchdog on cycles without any transfer or register write
    always @(posedge clk)
    begin : watchdog
        int unsigned idle_cycles;
        if (!rst_n)
            idle_cycles = 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [aahc_pkg::CFG_W-1:0] lo;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one frame set at the field extremes under reset thresholds
        for (int f = 0; f < 8; f++)
        begin
            sample_queue.push_back(12'hfff);
            sample_queue.push_back(f[0] ? 12'hfff : 12'h000);
            sample_queue.push_back(f[0] ? 12'h555 : 12'haaa);
        end
        queue_samples(196);
        drain();

        // zero thresholds: any nonzero sum means cutoff
        write_config(16'h0000, 16'h0000, 16'hffff, 16'h0000);
        queue_samples(196);
        drain();

        // top thresholds: the ring can never reach them
        write_config(16'hffff, 16'hffff, 16'h0000, 16'hffff);
        queue_samples(196);
        drain();

        // crossed thresholds, cutoff test has priority
        write_config(16'd30000, 16'd45000, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
        queue_samples(196);
        drain();

        for (int p = 0; p < 2; p++)
        begin
            lo = 16'($urandom_range(20000, 50000));
            write_config(lo + 16'($urandom_range(0, 8000)), lo,
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            queue_samples(196);
            drain();
        end

        mismatches = mismatches + frame_results_due.size();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: sim.f
design/aahc_pkg.sv
design/aahc_divider.sv
design/aahc_acc_mem.sv
design/aahc_ring.sv
design/adc_average_hysteresis_cutoff.sv
tb/tb.sv
